>>> hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg
// Shared widths, codes and defaults for the fit block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int SLOT_W     = 4;
  localparam int SIZE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int BLOCKS_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd2;

  localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } fba_state_t;

endpackage

>>> hw/rtl/fba_space_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_space_ram
// Free-space table: one write port, one registered read port. Per-entry
// valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module fba_space_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> hw/rtl/fba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ctrl
// Item sequencer: direct loads, table scan for requests, best/first pick
// tracking, write-back of the chosen block and the result register.
// ----------------------------------------------------------------------------
module fba_ctrl #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [fba_pkg::SLOT_W-1:0]    in_block_slot,
  input  logic [fba_pkg::SIZE_W-1:0]    in_size_value,
  input  logic                          fit_mode,
  input  logic [CNT_W-1:0]              scan_cnt,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [SIZE_BITS-1:0]          wr_data,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [SIZE_BITS-1:0]          rd_data,
  output logic                          out_strobe,
  output logic [fba_pkg::STATUS_W-1:0]  out_status,
  output logic [fba_pkg::SLOT_W-1:0]    out_granted_block,
  output logic [fba_pkg::SIZE_W-1:0]    out_space_left
);
  import fba_pkg::*;

  localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

  fba_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] pick_val_r, pick_val_nxt;
  logic [SIZE_W-1:0]    req_r, req_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_block_r, out_block_nxt;
  logic [SIZE_W-1:0]    out_space_r, out_space_nxt;

  logic                 issue;
  logic                 fits;
  logic                 slot_ok;
  logic [SIZE_BITS-1:0] new_val;
  logic [SIZE_BITS-1:0] load_val;

  assign issue    = (state_r == S_SCAN) && (rd_idx_r != cnt_r);
  assign fits     = CMP_W'(rd_data) >= CMP_W'(req_r);
  assign slot_ok  = int'(in_block_slot) < NUM_BLOCKS;
  assign load_val = SIZE_BITS'(in_size_value);
  assign new_val  = SIZE_BITS'(CMP_W'(pick_val_r) - CMP_W'(req_r));
  assign rd_addr  = issue ? rd_idx_r[IDX_W-1:0] : '0;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    pick_val_nxt   = pick_val_r;
    req_nxt        = req_r;
    out_vld_nxt    = 1'b0;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_space_nxt  = out_space_r;
    wr_en          = 1'b0;
    wr_addr        = IDX_W'(in_block_slot);
    wr_data        = load_val;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_LOAD) begin
            wr_en          = slot_ok;
            out_vld_nxt    = 1'b1;
            out_status_nxt = ST_LOADED;
            out_block_nxt  = in_block_slot;
            out_space_nxt  = slot_ok ? SIZE_W'(load_val) : '0;
          end else begin
            state_nxt  = S_SCAN;
            rd_idx_nxt = '0;
            cnt_nxt    = scan_cnt;
            found_nxt  = 1'b0;
            req_nxt    = in_size_value;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (chk_vld_r && fits &&
            (!found_r || (fit_mode == FIT_BEST && rd_data < pick_val_r))) begin
          found_nxt    = 1'b1;
          pick_nxt     = chk_idx_r;
          pick_val_nxt = rd_data;
        end
        if (!issue && !chk_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt   = S_IDLE;
        out_vld_nxt = 1'b1;
        if (found_r) begin
          wr_en          = 1'b1;
          wr_addr        = pick_r;
          wr_data        = new_val;
          out_status_nxt = ST_ALLOCATED;
          out_block_nxt  = SLOT_W'(pick_r);
          out_space_nxt  = SIZE_W'(new_val);
        end else begin
          out_status_nxt = ST_NONE;
          out_block_nxt  = '0;
          out_space_nxt  = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cnt_r        <= cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_r      <= found_nxt;
    pick_r       <= pick_nxt;
    pick_val_r   <= pick_val_nxt;
    req_r        <= req_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_space_r  <= out_space_nxt;
  end

  assign out_strobe        = out_vld_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_block_r;
  assign out_space_left    = out_space_r;

endmodule

>>> hw/rtl/fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_block_allocator
// First-fit / best-fit block allocator over a free-space table.
//
// Channel   Ports                                         Handshake
// input     in_cmd, in_block_slot, in_size_value          start & !busy
// result    out_status, out_granted_block, out_space_left out_strobe, 1 cycle
// config    cfg_idx, cfg_data                             cfg_we
//
// A load's result shows the cycle after acceptance and busy stays low. A request
// scans min(blocks_in_use, NUM_BLOCKS) blocks: one table read per block through
// the single RAM read port, then the last compare, a step to close the scan and
// write-back. Its result shows as busy falls. Synchronous reset clears the table
// (valid bits), the configuration and the sequencer. The receiver cannot stall;
// busy holds off starts.
// ----------------------------------------------------------------------------
module fit_block_allocator #(
  parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [fba_pkg::SLOT_W-1:0]     in_block_slot,
  input  logic [fba_pkg::SIZE_W-1:0]     in_size_value,
  output logic                           out_strobe,
  output logic [fba_pkg::STATUS_W-1:0]   out_status,
  output logic [fba_pkg::SLOT_W-1:0]     out_granted_block,
  output logic [fba_pkg::SIZE_W-1:0]     out_space_left,
  input  logic                           cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic                 fit_mode_r, fit_mode_nxt;
  logic [BLOCKS_W-1:0]  blocks_r, blocks_nxt;
  logic [CNT_W-1:0]     scan_cnt;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_data;

  always_comb begin
    fit_mode_nxt = fit_mode_r;
    blocks_nxt   = blocks_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FIT_MODE:      fit_mode_nxt = cfg_data[0];
        CFG_BLOCKS_IN_USE: blocks_nxt   = cfg_data[BLOCKS_W-1:0];
        default:           fit_mode_nxt = fit_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      blocks_r   <= BLOCKS_RESET;
    end else begin
      fit_mode_r <= fit_mode_nxt;
      blocks_r   <= blocks_nxt;
    end
  end

  assign scan_cnt = (int'(blocks_r) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_r);

  fba_space_ram #(
    .DEPTH  (NUM_BLOCKS),
    .ADDR_W (IDX_W),
    .DATA_W (SIZE_BITS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_block_slot     (in_block_slot),
    .in_size_value     (in_size_value),
    .fit_mode          (fit_mode_r),
    .scan_cnt          (scan_cnt),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_space_left    (out_space_left)
  );

endmodule

>>> hw/rtl/fba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks for the fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_cmd,
  input logic                         out_strobe,
  input logic [fba_pkg::STATUS_W-1:0] out_status,
  input logic [fba_pkg::SLOT_W-1:0]   out_granted_block,
  input logic [fba_pkg::SIZE_W-1:0]   out_space_left
);
  import fba_pkg::*;

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> (out_strobe && out_status == ST_LOADED))
    else $error("load item without loaded result");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_REQUEST) |=> (busy && !out_strobe))
    else $error("request item did not raise busy");

  a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe &&
                     (out_status == ST_ALLOCATED || out_status == ST_NONE)))
    else $error("request finished without a result");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_NONE) |-> (out_granted_block == '0 &&
                                               out_space_left == '0))
    else $error("not-allocated result carries data");

endmodule

bind fit_block_allocator fba_checker u_fba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_cmd            (in_cmd),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_granted_block (out_granted_block),
  .out_space_left    (out_space_left)
);

>>> test/fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_block_allocator_tb
// Self-checking bench for the first-fit / best-fit block allocator. A short
// table of load and request items with register writes between them comes
// first; random phases follow, each with its own fit mode and block count.
// Every accepted item is run through a local model of the free-space table,
// and each strobed result is checked field by field against the oldest
// expectation: the row's typed result where it gives one, else the prediction.
// ----------------------------------------------------------------------------
module fit_block_allocator_tb;

  import fba_pkg::*;

  localparam int N_BLK       = NUM_BLOCKS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
  } alloc_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   blk;
    logic [SIZE_W-1:0]   left;
  } alloc_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    alloc_item_t            it;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic                   typed;
    alloc_result_t          want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_cmd = CMD_LOAD;
  logic [SLOT_W-1:0]     in_block_slot = '0;
  logic [SIZE_W-1:0]     in_size_value = '0;
  logic                  out_strobe;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_W-1:0]     out_granted_block;
  logic [SIZE_W-1:0]     out_space_left;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [SIZE_W-1:0]   free_tbl [N_BLK];
  logic                fit_cfg = FIT_FIRST;
  logic [BLOCKS_W-1:0] count_cfg = BLOCKS_RESET;

  alloc_result_t pending_results [$];
  stim_row_t     stim_rows [$];
  int            errors = 0;
  int            stall_cycles = 0;

  fit_block_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_block_slot     (in_block_slot),
    .in_size_value     (in_size_value),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_space_left    (out_space_left),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int searched_blocks();
    return (count_cfg > N_BLK) ? N_BLK : int'(count_cfg);
  endfunction

  // Applies one item to the local table and returns the result it gives
  function automatic alloc_result_t predict_alloc(input alloc_item_t it);
    alloc_result_t res;
    int            lim;
    int            pick;
    logic          found;
    res   = '0;
    lim   = searched_blocks();
    pick  = 0;
    found = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      free_tbl[it.slot] = it.size;
      res.status = ST_LOADED;
      res.blk    = it.slot;
      res.left   = it.size;
      return res;
    end
    for (int k = 0; k < lim; k++) begin
      if (!(found && fit_cfg == FIT_FIRST) && free_tbl[k] >= it.size) begin
        if (!found || free_tbl[k] < free_tbl[pick]) begin
          pick  = k;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      free_tbl[pick] = free_tbl[pick] - it.size;
      res.status = ST_ALLOCATED;
      res.blk    = SLOT_W'(pick);
      res.left   = free_tbl[pick];
    end else begin
      res.status = ST_NONE;
    end
    return res;
  endfunction

  function automatic stim_row_t item_row(input logic cmd, input int slot, input int size);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_ITEM;
    r.it.cmd  = cmd;
    r.it.slot = SLOT_W'(slot);
    r.it.size = SIZE_W'(size);
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic cmd, input int slot, input int size,
                                          input logic [STATUS_W-1:0] status,
                                          input int blk, input int left);
    stim_row_t r;
    r             = item_row(cmd, slot, size);
    r.typed       = 1'b1;
    r.want.status = status;
    r.want.blk    = SLOT_W'(blk);
    r.want.left   = SIZE_W'(left);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = CFG_DATA_W'(data);
    return r;
  endfunction

  function automatic alloc_item_t random_item();
    alloc_item_t it;
    int          lim;
    int          roll;
    logic [SIZE_W-1:0] base;
    logic [SIZE_W-1:0] trim;
    lim  = searched_blocks();
    roll = $urandom_range(0, 99);
    it   = '0;
    if ($urandom_range(0, 99) < 35) begin
      it.cmd  = CMD_LOAD;
      it.slot = (lim > 0 && $urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, lim - 1))
                                                       : SLOT_W'($urandom);
      if (roll < 40)      it.size = SIZE_W'($urandom);
      else if (roll < 80) it.size = SIZE_W'($urandom_range(0, 2000));
      else if (roll < 90) it.size = '1;
      else                it.size = '0;
      return it;
    end
    it.cmd  = CMD_REQUEST;
    it.slot = SLOT_W'($urandom);
    if (lim == 0 || roll < 15) begin
      it.size = SIZE_W'($urandom);
      return it;
    end
    base = free_tbl[$urandom_range(0, lim - 1)];
    trim = SIZE_W'($urandom_range(1, 64));
    if (roll < 20)      it.size = '0;
    else if (roll < 45) it.size = base;
    else if (roll < 65) it.size = (base > trim) ? base - trim : base;
    else if (roll < 85) it.size = SIZE_W'($urandom_range(1, 255));
    else if (roll < 88) it.size = '1;
    else                it.size = base + trim;
    return it;
  endfunction

  // Entered and left at a falling edge; start is still high on return
  task automatic issue_item(input alloc_item_t it, input int unsigned gap,
                            input logic typed, input alloc_result_t want);
    alloc_result_t got;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= it.cmd;
    in_block_slot <= it.slot;
    in_size_value <= it.size;
    do @(posedge clk); while (busy);
    got = predict_alloc(it);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_MODE) fit_cfg = data[0];
    else                     count_cfg = data;
  endtask

  // Result checker and stall watchdog
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((start && !busy) || out_strobe) stall_cycles <= 0;
      else                                stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("fit_block_allocator_tb failed");
        $finish;
      end
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result status %0d block %0d left %0d", $time,
                   out_status, out_granted_block, out_space_left);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_status !== exp_res.status) begin
            errors = errors + 1;
            $display("%0t: status expected %0d got %0d", $time, exp_res.status, out_status);
          end
          if (out_granted_block !== exp_res.blk) begin
            errors = errors + 1;
            $display("%0t: granted_block expected %0d got %0d", $time, exp_res.blk,
                     out_granted_block);
          end
          if (out_space_left !== exp_res.left) begin
            errors = errors + 1;
            $display("%0t: space_left expected %0d got %0d", $time, exp_res.left,
                     out_space_left);
          end
        end
      end
    end
  end

  initial begin
    alloc_item_t it;
    int unsigned gap;
    int          idle_style;
    int          drain_at;
    int          blocks;
    logic        mode;

    foreach (free_tbl[k]) free_tbl[k] = '0;

    // Empty table, extremes of size and slot, block count zero and saturated
    stim_rows.push_back(typed_row(CMD_REQUEST, 0, 1, ST_NONE, 0, 0));
    stim_rows.push_back(typed_row(CMD_REQUEST, 9, 0, ST_ALLOCATED, 0, 0));
    stim_rows.push_back(typed_row(CMD_LOAD, 15, 65535, ST_LOADED, 15, 65535));
    stim_rows.push_back(typed_row(CMD_LOAD, 0, 0, ST_LOADED, 0, 0));
    stim_rows.push_back(typed_row(CMD_REQUEST, 15, 65535, ST_ALLOCATED, 15, 0));
    stim_rows.push_back(typed_row(CMD_LOAD, 3, 100, ST_LOADED, 3, 100));
    stim_rows.push_back(item_row(CMD_LOAD, 7, 40));
    stim_rows.push_back(item_row(CMD_LOAD, 9, 60));
    stim_rows.push_back(item_row(CMD_REQUEST, 0, 50));
    stim_rows.push_back(typed_row(CMD_REQUEST, 0, 65535, ST_NONE, 0, 0));
    stim_rows.push_back(cfg_row(CFG_FIT_MODE, 5'h1F));
    stim_rows.push_back(item_row(CMD_REQUEST, 0, 45));
    stim_rows.push_back(item_row(CMD_LOAD, 5, 40));
    stim_rows.push_back(item_row(CMD_REQUEST, 0, 30));
    stim_rows.push_back(item_row(CMD_REQUEST, 0, 0));
    stim_rows.push_back(cfg_row(CFG_BLOCKS_IN_USE, 0));
    stim_rows.push_back(typed_row(CMD_REQUEST, 0, 0, ST_NONE, 0, 0));
    stim_rows.push_back(cfg_row(CFG_BLOCKS_IN_USE, 31));
    stim_rows.push_back(item_row(CMD_LOAD, 15, 1000));
    stim_rows.push_back(item_row(CMD_REQUEST, 0, 900));
    stim_rows.push_back(cfg_row(CFG_BLOCKS_IN_USE, 1));
    stim_rows.push_back(item_row(CMD_REQUEST, 0, 0));
    stim_rows.push_back(typed_row(CMD_REQUEST, 0, 1, ST_NONE, 0, 0));
    stim_rows.push_back(cfg_row(CFG_FIT_MODE, 5'h1E));
    stim_rows.push_back(cfg_row(CFG_BLOCKS_IN_USE, 16));
    stim_rows.push_back(item_row(CMD_LOAD, 10, 16'h5555));
    stim_rows.push_back(item_row(CMD_LOAD, 11, 16'hAAAA));
    stim_rows.push_back(item_row(CMD_REQUEST, 6, 16'hAAAA));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        settle();
        write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_data);
      end else begin
        issue_item(stim_rows[r].it, $urandom_range(0, 3), stim_rows[r].typed,
                   stim_rows[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mode = FIT_FIRST; blocks = 16; end
        1: begin mode = FIT_BEST;  blocks = 16; end
        2: begin mode = FIT_FIRST; blocks = 1;  end
        3: begin mode = FIT_BEST;  blocks = 1;  end
        4: begin mode = FIT_BEST;  blocks = 31; end
        default: begin
          mode   = logic'($urandom_range(0, 1));
          blocks = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 31);
        end
      endcase
      settle();
      write_reg(CFG_FIT_MODE, {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)} | CFG_DATA_W'(mode));
      write_reg(CFG_BLOCKS_IN_USE, CFG_DATA_W'(blocks));

      idle_style = $urandom_range(0, 2);
      drain_at   = (p == 0) ? 60 : ($urandom_range(0, 1) ? $urandom_range(0, PHASE_ITEMS - 1)
                                                          : -1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == drain_at) settle();
        case (idle_style)
          0:       gap = 0;
          1:       gap = $urandom_range(0, 17);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
        it = random_item();
        issue_item(it, gap, 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("fit_block_allocator_tb passed");
    end else begin
      $display("fit_block_allocator_tb failed");
    end
    $finish;
  end

endmodule
